[design/usv_pkg.sv]
// Shared types, widths and constants for the UV sphere vertex generator.
// No dependencies; each design file but usv_checker uses its scoped names.
package usv_pkg;

   localparam int DefaultMaxRings   = 256;
   localparam int DefaultMaxStacks  = 256;
   localparam int DefaultCordicSteps = 16;

   localparam int IdxW   = 9;    // stack/sector index and count registers
   localparam int RadW   = 16;
   localparam int AngW   = 32;   // one turn = 2^32
   localparam int NumW   = 41;   // widest divider numerator
   localparam int TexW   = 17;
   localparam int BaseW  = 17;
   localparam int MaskW  = 2;
   localparam int PosW   = 17;
   localparam int Q14W   = 16;
   localparam int CordW  = 34;   // Q2.30 datapath with headroom
   localparam int AtanEntries = 24;

   localparam int DivSideW  = BaseW + MaskW;
   localparam int CordSideW = DivSideW + 2 * TexW;

   localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
   localparam logic signed [CordW-1:0] Q14One     = 34'sd16384;

   localparam logic [31:0] AtanTurns [AtanEntries] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [1:0] {
      CSR_RADIUS      = 2'd0,
      CSR_RING_COUNT  = 2'd1,
      CSR_STACK_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BaseW-1:0] base;
      logic [MaskW-1:0] mask;
   } div_side_type;

   typedef struct packed {
      div_side_type     grid;
      logic [TexW-1:0]  tex_s;
      logic [TexW-1:0]  tex_t;
   } cord_side_type;

endpackage

[design/usv_div.sv]
// Pipelined restoring divider, several lanes, a few quotient bits per stage.
// Uses usv_pkg. Users hold divisors static while items are in flight; unchecked.
module usv_div #(
   parameter int NUM_W  = usv_pkg::NumW,
   parameter int DEN_W  = usv_pkg::IdxW,
   parameter int LANES  = 4,
   parameter int SIDE_W = usv_pkg::DivSideW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    in_num  [LANES],
   input  logic [DEN_W-1:0]    den     [LANES],
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [((NUM_W+3)/4)*4-1:0] out_quo [LANES],
   output logic [SIDE_W-1:0]   out_side
);
   localparam int Bps    = 4;
   localparam int Stages = (NUM_W + Bps - 1) / Bps;
   localparam int PadW   = Stages * Bps;

   logic [PadW-1:0]   wq_ff   [Stages][LANES];
   logic [DEN_W-1:0]  rem_ff  [Stages][LANES];
   logic [SIDE_W-1:0] side_ff [Stages];
   logic              vld_ff  [Stages];

   logic [PadW-1:0]   src_wq   [Stages][LANES];
   logic [DEN_W-1:0]  src_rem  [Stages][LANES];
   logic [SIDE_W-1:0] src_side [Stages];
   logic              src_vld  [Stages];

   logic [PadW-1:0]   wq_in  [Stages][LANES];
   logic [DEN_W-1:0]  rem_in [Stages][LANES];

   genvar gs, gl;
   generate
      for (gs = 0; gs < Stages; gs++) begin : g_stage
         if (gs == 0) begin : g_first
            for (gl = 0; gl < LANES; gl++) begin : g_lane
               assign src_wq[0][gl]  = PadW'(in_num[gl]);
               assign src_rem[0][gl] = '0;
            end
            assign src_side[0] = in_side;
            assign src_vld[0]  = in_valid;
         end else begin : g_next
            for (gl = 0; gl < LANES; gl++) begin : g_lane
               assign src_wq[gs][gl]  = wq_ff[gs-1][gl];
               assign src_rem[gs][gl] = rem_ff[gs-1][gl];
            end
            assign src_side[gs] = side_ff[gs-1];
            assign src_vld[gs]  = vld_ff[gs-1];
         end

         for (gl = 0; gl < LANES; gl++) begin : g_step
            logic [PadW-1:0]  w;
            logic [DEN_W-1:0] r;
            logic [DEN_W:0]   t;
            always_comb begin
               w = src_wq[gs][gl];
               r = src_rem[gs][gl];
               t = '0;
               for (int b = 0; b < Bps; b++) begin
                  t = {r, w[PadW-1]};
                  w = {w[PadW-2:0], 1'b0};
                  if (t >= {1'b0, den[gl]}) begin
                     t    = t - {1'b0, den[gl]};
                     w[0] = 1'b1;
                  end
                  r = t[DEN_W-1:0];
               end
               wq_in[gs][gl]  = w;
               rem_in[gs][gl] = r;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[gs] <= 1'b0;
            end else if (en) begin
               vld_ff[gs] <= src_vld[gs];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[gs] <= src_side[gs];
               for (int l = 0; l < LANES; l++) begin
                  wq_ff[gs][l]  <= wq_in[gs][l];
                  rem_ff[gs][l] <= rem_in[gs][l];
               end
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = wq_ff[Stages-1][l];
      end
   end

endmodule

[design/usv_cordic.sv]
// Two-lane pipelined rotation CORDIC: quadrant fold, one iteration per stage,
// then rounding to Q1.14 with saturation and quadrant unfold. Uses usv_pkg.
module usv_cordic #(
   parameter int STEPS  = usv_pkg::DefaultCordicSteps,
   parameter int SIDE_W = usv_pkg::CordSideW
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [usv_pkg::AngW-1:0]           in_ang  [2],
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic signed [usv_pkg::Q14W-1:0]    out_cos [2],
   output logic signed [usv_pkg::Q14W-1:0]    out_sin [2],
   output logic [SIDE_W-1:0]                  out_side
);
   localparam int W = usv_pkg::CordW;

   logic signed [W-1:0] x_ff [STEPS+1][2];
   logic signed [W-1:0] y_ff [STEPS+1][2];
   logic signed [W-1:0] z_ff [STEPS+1][2];
   logic [1:0]          q_ff [STEPS+1][2];
   logic [SIDE_W-1:0]   side_ff [STEPS+1];
   logic                vld_ff  [STEPS+1];

   logic signed [usv_pkg::Q14W-1:0] cos_ff [2];
   logic signed [usv_pkg::Q14W-1:0] sin_ff [2];
   logic [SIDE_W-1:0]               side_out_ff;
   logic                            vld_out_ff;

   // fold the angle into [-1/8, 1/8) turn
   logic [1:0]           q_in [2];
   logic [31:0]          d_in [2];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         q_in[l] = 2'((in_ang[l] + 32'h2000_0000) >> 30);
         d_in[l] = in_ang[l] - {q_in[l], 30'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int l = 0; l < 2; l++) begin
            x_ff[0][l] <= usv_pkg::CordicGain;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= {{(W-32){d_in[l][31]}}, d_in[l]};
            q_ff[0][l] <= q_in[l];
         end
      end
   end

   genvar gk;
   generate
      for (gk = 1; gk <= STEPS; gk++) begin : g_iter
         localparam logic signed [W-1:0] Atan =
            W'(usv_pkg::AtanTurns[gk-1]);
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[gk] <= 1'b0;
            end else if (en) begin
               vld_ff[gk] <= vld_ff[gk-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[gk] <= side_ff[gk-1];
               for (int l = 0; l < 2; l++) begin
                  q_ff[gk][l] <= q_ff[gk-1][l];
                  if (!z_ff[gk-1][l][W-1]) begin
                     x_ff[gk][l] <= x_ff[gk-1][l] - (y_ff[gk-1][l] >>> (gk-1));
                     y_ff[gk][l] <= y_ff[gk-1][l] + (x_ff[gk-1][l] >>> (gk-1));
                     z_ff[gk][l] <= z_ff[gk-1][l] - Atan;
                  end else begin
                     x_ff[gk][l] <= x_ff[gk-1][l] + (y_ff[gk-1][l] >>> (gk-1));
                     y_ff[gk][l] <= y_ff[gk-1][l] - (x_ff[gk-1][l] >>> (gk-1));
                     z_ff[gk][l] <= z_ff[gk-1][l] + Atan;
                  end
               end
            end
         end
      end
   endgenerate

   // round half up to Q1.14, saturate, then unfold the quadrant
   logic signed [W-1:0]              xr [2];
   logic signed [W-1:0]              yr [2];
   logic signed [usv_pkg::Q14W-1:0]  c14 [2];
   logic signed [usv_pkg::Q14W-1:0]  s14 [2];
   logic signed [usv_pkg::Q14W-1:0]  cos_in [2];
   logic signed [usv_pkg::Q14W-1:0]  sin_in [2];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         xr[l] = (x_ff[STEPS][l] + W'(32768)) >>> 16;
         yr[l] = (y_ff[STEPS][l] + W'(32768)) >>> 16;
         if (xr[l] > usv_pkg::Q14One)       c14[l] = 16'sd16384;
         else if (xr[l] < -usv_pkg::Q14One) c14[l] = -16'sd16384;
         else                               c14[l] = xr[l][usv_pkg::Q14W-1:0];
         if (yr[l] > usv_pkg::Q14One)       s14[l] = 16'sd16384;
         else if (yr[l] < -usv_pkg::Q14One) s14[l] = -16'sd16384;
         else                               s14[l] = yr[l][usv_pkg::Q14W-1:0];
         case (q_ff[STEPS][l])
            2'd0: begin
               cos_in[l] = c14[l];
               sin_in[l] = s14[l];
            end
            2'd1: begin
               cos_in[l] = -s14[l];
               sin_in[l] = c14[l];
            end
            2'd2: begin
               cos_in[l] = -c14[l];
               sin_in[l] = -s14[l];
            end
            default: begin
               cos_in[l] = s14[l];
               sin_in[l] = -c14[l];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out_ff <= 1'b0;
      end else if (en) begin
         vld_out_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_out_ff <= side_ff[STEPS];
         for (int l = 0; l < 2; l++) begin
            cos_ff[l] <= cos_in[l];
            sin_ff[l] <= sin_in[l];
         end
      end
   end

   assign out_valid = vld_out_ff;
   assign out_side  = side_out_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

endmodule

[design/usv_mult.sv]
// Product stages: normal and z terms, then radius scaling of the x/y terms.
// The second stage is the result register. Uses usv_pkg.
module usv_mult (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [usv_pkg::Q14W-1:0]   cth,
   input  logic signed [usv_pkg::Q14W-1:0]   sth,
   input  logic signed [usv_pkg::Q14W-1:0]   cph,
   input  logic signed [usv_pkg::Q14W-1:0]   sph,
   input  logic [usv_pkg::RadW-1:0]          radius,
   input  usv_pkg::cord_side_type            in_side,
   output logic                              out_valid,
   output logic signed [usv_pkg::PosW-1:0]   pos_x,
   output logic signed [usv_pkg::PosW-1:0]   pos_y,
   output logic signed [usv_pkg::PosW-1:0]   pos_z,
   output logic signed [usv_pkg::Q14W-1:0]   norm_x,
   output logic signed [usv_pkg::Q14W-1:0]   norm_y,
   output logic signed [usv_pkg::Q14W-1:0]   norm_z,
   output logic signed [usv_pkg::Q14W-1:0]   tan_x,
   output logic signed [usv_pkg::Q14W-1:0]   tan_y,
   output usv_pkg::cord_side_type            out_side
);
   localparam int PW = 2 * usv_pkg::Q14W;          // sin*cos product
   localparam int RW = usv_pkg::RadW + 1;          // radius as signed
   localparam int LW = RW + PW;                    // radius * product

   logic signed [RW-1:0] rad_s;
   assign rad_s = $signed({1'b0, radius});

   // stage A
   logic signed [PW-1:0]            px_ff, py_ff, pz_ff;
   logic signed [usv_pkg::Q14W-1:0] cph_a_ff, sth_a_ff, cth_a_ff;
   usv_pkg::cord_side_type          side_a_ff;
   logic                            vld_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff     <= sph * cth;
         py_ff     <= sph * sth;
         pz_ff     <= PW'(rad_s * cph);
         cph_a_ff  <= cph;
         sth_a_ff  <= sth;
         cth_a_ff  <= cth;
         side_a_ff <= in_side;
      end
   end

   // stage B: scale by radius and round
   logic signed [LW-1:0] lx, ly;
   logic signed [PW-1:0] nx, ny, nz;
   assign lx = (rad_s * px_ff + LW'(1 << 27)) >>> 28;
   assign ly = (rad_s * py_ff + LW'(1 << 27)) >>> 28;
   assign nx = (px_ff + PW'(1 << 13)) >>> 14;
   assign ny = (py_ff + PW'(1 << 13)) >>> 14;
   assign nz = (pz_ff + PW'(1 << 13)) >>> 14;

   logic                            vld_b_ff;
   logic signed [usv_pkg::PosW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [usv_pkg::Q14W-1:0] norm_x_ff, norm_y_ff, norm_z_ff;
   logic signed [usv_pkg::Q14W-1:0] tan_x_ff, tan_y_ff;
   usv_pkg::cord_side_type          side_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff  <= lx[usv_pkg::PosW-1:0];
         pos_y_ff  <= ly[usv_pkg::PosW-1:0];
         pos_z_ff  <= nz[usv_pkg::PosW-1:0];
         norm_x_ff <= nx[usv_pkg::Q14W-1:0];
         norm_y_ff <= ny[usv_pkg::Q14W-1:0];
         norm_z_ff <= cph_a_ff;
         tan_x_ff  <= -sth_a_ff;
         tan_y_ff  <= cth_a_ff;
         side_b_ff <= side_a_ff;
      end
   end

   assign out_valid = vld_b_ff;
   assign pos_x     = pos_x_ff;
   assign pos_y     = pos_y_ff;
   assign pos_z     = pos_z_ff;
   assign norm_x    = norm_x_ff;
   assign norm_y    = norm_y_ff;
   assign norm_z    = norm_z_ff;
   assign tan_x     = tan_x_ff;
   assign tan_y     = tan_y_ff;
   assign out_side  = side_b_ff;

endmodule

[design/uv_sphere_vertex_generator.sv]
// UV sphere vertex generator, top level.
// Depends on usv_pkg, usv_div, usv_cordic and usv_mult.
//
// Usage:
//   req_* carries one grid point (stack_index, sector_index) per transaction;
//   rsp_* returns its position, normal, texture coordinates, tangent, cell
//   base index and triangle mask, one transaction per request, in order.
//   csr_* writes radius, ring_count and stack_count; csr_ready is always high.
//   Write the registers only while no request is in flight.
// Pipeline: 1 clamp stage, 11 divider stages (four quotient bits each over
//   a 41-bit numerator), CORDIC_STEPS + 2 CORDIC stages, 2 multiply stages.
// Throughput: one transaction per cycle unless a result is held under rsp_stall;
//   every stage holds one item.
// Reset: clears all valid bits and loads radius 1.0, 32 rings, 16 stacks.
// Stall: while a result is held under rsp_stall, the whole pipeline holds
//   and req_stall is raised; nothing is dropped or repeated.
module uv_sphere_vertex_generator #(
   parameter int MAX_RINGS    = usv_pkg::DefaultMaxRings,
   parameter int MAX_STACKS   = usv_pkg::DefaultMaxStacks,
   parameter int CORDIC_STEPS = usv_pkg::DefaultCordicSteps
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [usv_pkg::IdxW-1:0]          req_stack_index,
   input  logic [usv_pkg::IdxW-1:0]          req_sector_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [usv_pkg::PosW-1:0]   rsp_pos_x,
   output logic signed [usv_pkg::PosW-1:0]   rsp_pos_y,
   output logic signed [usv_pkg::PosW-1:0]   rsp_pos_z,
   output logic signed [usv_pkg::Q14W-1:0]   rsp_norm_x,
   output logic signed [usv_pkg::Q14W-1:0]   rsp_norm_y,
   output logic signed [usv_pkg::Q14W-1:0]   rsp_norm_z,
   output logic [usv_pkg::TexW-1:0]          rsp_tex_s,
   output logic [usv_pkg::TexW-1:0]          rsp_tex_t,
   output logic signed [usv_pkg::Q14W-1:0]   rsp_tan_x,
   output logic signed [usv_pkg::Q14W-1:0]   rsp_tan_y,
   output logic [usv_pkg::BaseW-1:0]         rsp_cell_base,
   output logic [usv_pkg::MaskW-1:0]         rsp_tri_mask,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [usv_pkg::RadW-1:0]          csr_data
);
   localparam int IW    = usv_pkg::IdxW;
   localparam int NW    = usv_pkg::NumW;
   localparam int QW    = ((NW + 3) / 4) * 4;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // configuration registers
   logic [usv_pkg::RadW-1:0] radius_ff;
   logic [IW-1:0]            ring_count_ff, stack_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= 16'd256;
         ring_count_ff  <= 9'd32;
         stack_count_ff <= 9'd16;
      end else if (csr_valid && csr_ready) begin
         unique case (usv_pkg::csr_index_type'(csr_index))
            usv_pkg::CSR_RADIUS:      radius_ff      <= csr_data;
            usv_pkg::CSR_RING_COUNT:  ring_count_ff  <= csr_data[IW-1:0];
            usv_pkg::CSR_STACK_COUNT: stack_count_ff <= csr_data[IW-1:0];
            default: ;
         endcase
      end
   end

   // effective counts
   logic [IW-1:0] rings, stacks;
   always_comb begin
      if (ring_count_ff < IW'(3))                rings = IW'(3);
      else if (32'(ring_count_ff) > MAX_RINGS)   rings = IW'(MAX_RINGS);
      else                                       rings = ring_count_ff;
      if (stack_count_ff < IW'(2))               stacks = IW'(2);
      else if (32'(stack_count_ff) > MAX_STACKS) stacks = IW'(MAX_STACKS);
      else                                       stacks = stack_count_ff;
   end

   // clamp stage: indices, numerators, cell base and triangle mask
   logic [IW-1:0]             st, se;
   logic [2*IW:0]             base_full;
   logic [usv_pkg::MaskW-1:0] mask;
   logic [NW-1:0]             num_in [4];
   always_comb begin
      st = (req_stack_index > stacks) ? stacks : req_stack_index;
      se = (req_sector_index > rings) ? rings : req_sector_index;
      base_full = (2*IW+1)'(st * ({1'b0, rings} + 10'd1)) + (2*IW+1)'(se);
      mask = '0;
      if (st < stacks && se < rings) begin
         mask[0] = (st != '0);
         mask[1] = (st != stacks - IW'(1));
      end
      num_in[0] = {se, 32'b0} + NW'(rings >> 1);
      num_in[1] = NW'({st, 31'b0}) + NW'(stacks >> 1);
      num_in[2] = NW'({se, 16'b0}) + NW'(rings >> 1);
      num_in[3] = NW'({st, 16'b0}) + NW'(stacks >> 1);
   end

   logic                  vld0_ff;
   logic [NW-1:0]         num_ff [4];
   usv_pkg::div_side_type side0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff        <= num_in;
         side0_ff.base <= base_full[usv_pkg::BaseW-1:0];
         side0_ff.mask <= mask;
      end
   end

   // angle and texture division
   logic [IW-1:0]         den [4];
   logic                  div_valid;
   logic [QW-1:0]         quo [4];
   usv_pkg::div_side_type div_side;
   assign den[0] = rings;
   assign den[1] = stacks;
   assign den[2] = rings;
   assign den[3] = stacks;

   usv_div #(
      .NUM_W  (NW),
      .DEN_W  (IW),
      .LANES  (4),
      .SIDE_W (usv_pkg::DivSideW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld0_ff),
      .in_num    (num_ff),
      .den       (den),
      .in_side   (side0_ff),
      .out_valid (div_valid),
      .out_quo   (quo),
      .out_side  (div_side)
   );

   logic [usv_pkg::AngW-1:0] ang [2];
   usv_pkg::cord_side_type   cord_side_in, cord_side;
   assign ang[0]             = quo[0][usv_pkg::AngW-1:0];
   assign ang[1]             = quo[1][usv_pkg::AngW-1:0];
   assign cord_side_in.grid  = div_side;
   assign cord_side_in.tex_s = quo[2][usv_pkg::TexW-1:0];
   assign cord_side_in.tex_t = quo[3][usv_pkg::TexW-1:0];

   logic                            cord_valid;
   logic signed [usv_pkg::Q14W-1:0] cosv [2];
   logic signed [usv_pkg::Q14W-1:0] sinv [2];

   usv_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (usv_pkg::CordSideW)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_ang    (ang),
      .in_side   (cord_side_in),
      .out_valid (cord_valid),
      .out_cos   (cosv),
      .out_sin   (sinv),
      .out_side  (cord_side)
   );

   usv_pkg::cord_side_type rsp_side;

   usv_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cord_valid),
      .cth       (cosv[0]),
      .sth       (sinv[0]),
      .cph       (cosv[1]),
      .sph       (sinv[1]),
      .radius    (radius_ff),
      .in_side   (cord_side),
      .out_valid (rsp_valid),
      .pos_x     (rsp_pos_x),
      .pos_y     (rsp_pos_y),
      .pos_z     (rsp_pos_z),
      .norm_x    (rsp_norm_x),
      .norm_y    (rsp_norm_y),
      .norm_z    (rsp_norm_z),
      .tan_x     (rsp_tan_x),
      .tan_y     (rsp_tan_y),
      .out_side  (rsp_side)
   );

   assign rsp_tex_s     = rsp_side.tex_s;
   assign rsp_tex_t     = rsp_side.tex_t;
   assign rsp_cell_base = rsp_side.grid.base;
   assign rsp_tri_mask  = rsp_side.grid.mask;

endmodule

[design/usv_checker.sv]
// Port-level checks for the UV sphere vertex generator, bound to the top.
// Depends on uv_sphere_vertex_generator's ports only.
module usv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_tex_s,
   input logic [16:0] rsp_tex_t,
   input logic [15:0] rsp_norm_z,
   input logic [1:0]  rsp_tri_mask
);
   // back pressure reaches the request side at once
   a_stall_prop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("held result did not stall requests");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_tex_s)
                                    && $stable(rsp_tri_mask)))
      else $error("stalled transaction changed");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tex_s <= 17'd65536 && rsp_tex_t <= 17'd65536))
      else $error("texture coordinate beyond one");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_norm_z) <= 16'sd16384
                     && $signed(rsp_norm_z) >= -16'sd16384))
      else $error("normal z out of unit range");

endmodule

bind uv_sphere_vertex_generator usv_checker u_usv_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_tex_s    (rsp_tex_s),
   .rsp_tex_t    (rsp_tex_t),
   .rsp_norm_z   (rsp_norm_z),
   .rsp_tri_mask (rsp_tri_mask)
);
